@@ rtl/core/r2nv_pkg.sv @@
// shared constants, codes and pixel math for the rgb to nv12 converter
package r2nv_pkg;

    // geometry registers and their reset values
    localparam int DIM_W = 13;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [DIM_W-1:0] DIM_MIN      = 13'd2;

    // output field widths
    localparam int LUMA_OFS_W   = 24;
    localparam int CHROMA_OFS_W = 23;

    // line store word: three 9-bit pair sums, red in the top bits
    localparam int SUM_W  = 9;
    localparam int LINE_W = 3 * SUM_W;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // bt.601 limited range coefficients
    localparam logic [7:0] Y_KR = 8'd66;
    localparam logic [7:0] Y_KG = 8'd129;
    localparam logic [7:0] Y_KB = 8'd25;
    localparam logic [7:0] Y_ROUND = 8'd128;
    localparam logic [7:0] Y_OFS = 8'd16;

    localparam logic signed [7:0] CB_KR = -8'sd38;
    localparam logic signed [7:0] CB_KG = -8'sd74;
    localparam logic signed [7:0] CB_KB = 8'sd112;
    localparam logic signed [7:0] CR_KR = 8'sd112;
    localparam logic signed [7:0] CR_KG = -8'sd94;
    localparam logic signed [7:0] CR_KB = -8'sd18;

    // rounding 128 plus chroma offset 128 << 8
    localparam logic signed [17:0] C_BIAS = 18'sd32896;
    localparam logic [7:0] BYTE_MAX = 8'd255;

    function automatic logic [7:0] luma_byte(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        logic [16:0] acc;
        acc = 17'(Y_KR) * 17'(r) + 17'(Y_KG) * 17'(g) + 17'(Y_KB) * 17'(b)
              + 17'(Y_ROUND);
        // top of range is 235, no clamp needed
        return 8'(acc[15:8] + Y_OFS);
    endfunction

    function automatic logic [7:0] chroma_byte(input logic [7:0] ar, input logic [7:0] ag,
                                               input logic [7:0] ab,
                                               input logic signed [7:0] kr,
                                               input logic signed [7:0] kg,
                                               input logic signed [7:0] kb);
        logic signed [17:0] er;
        logic signed [17:0] eg;
        logic signed [17:0] eb;
        logic signed [17:0] acc;
        logic [7:0] res;
        er  = signed'(18'(ar));
        eg  = signed'(18'(ag));
        eb  = signed'(18'(ab));
        acc = 18'(kr) * er + 18'(kg) * eg + 18'(kb) * eb + C_BIAS;
        if (acc < 0) begin
            res = 8'd0;
        end else if (acc[17:16] != 2'b00) begin
            res = BYTE_MAX;
        end else begin
            res = acc[15:8];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/rgb_to_nv12_converter_core.sv @@
// rgb888 pixel stream to bt.601 nv12 luma and interleaved chroma words
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------------
//  s_       | in  | s_valid/s_ready  | s_red, s_green, s_blue
//  m_       | out | m_valid/m_ready  | m_luma, m_luma_offset, m_chroma_valid, m_cb,
//           |     |                  | m_cr, m_chroma_offset, m_frame_end
//  cfg_     | in  | cfg_wr_en        | cfg_index, cfg_wr_data
//
//  one pixel per clock sustained while m_ready is high; an accepted word passes the input
//  stage (with the registered line store read), then the result register driving m_
//  reset: geometry 640x480, position at row 0 column 0, line store contents undefined
//  and never cleared
//  m_ready low holds the result; one more word waits in the input stage, then s_ready drops
module rgb_to_nv12_converter_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [0:0]                            cfg_index,
    input  logic [r2nv_pkg::DIM_W-1:0]            cfg_wr_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_red,
    input  logic [7:0]                            s_green,
    input  logic [7:0]                            s_blue,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [7:0]                            m_luma,
    output logic [r2nv_pkg::LUMA_OFS_W-1:0]       m_luma_offset,
    output logic                                  m_chroma_valid,
    output logic [7:0]                            m_cb,
    output logic [7:0]                            m_cr,
    output logic [r2nv_pkg::CHROMA_OFS_W-1:0]     m_chroma_offset,
    output logic                                  m_frame_end
);

    localparam int DIM_W      = r2nv_pkg::DIM_W;
    localparam int SUM_W      = r2nv_pkg::SUM_W;
    localparam int LINE_W     = r2nv_pkg::LINE_W;
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CMP_W      = DIM_W + 1;
    localparam int PROD_W     = ROW_W + DIM_W + 1;

    localparam logic [CMP_W-1:0] MAX_W_CMP = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MAX_H_CMP = CMP_W'(MAX_HEIGHT);

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    // position and previous pixel
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [23:0]      left_reg;

    logic             accept;
    logic             last_col;
    logic             last_row;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [IDX_W-1:0] line_idx;
    logic             line_wr_en;

    // line store of even row pair sums
    logic [LINE_W-1:0] line_mem [LINE_DEPTH];
    logic [LINE_W-1:0] line_rd_reg;

    // input stage
    logic             s1_valid_reg;
    logic [7:0]       s1_red_reg;
    logic [7:0]       s1_green_reg;
    logic [7:0]       s1_blue_reg;
    logic [SUM_W-1:0] s1_sum_r_reg;
    logic [SUM_W-1:0] s1_sum_g_reg;
    logic [SUM_W-1:0] s1_sum_b_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [DIM_W-1:0] s1_w_reg;
    logic             s1_chroma_reg;
    logic             s1_end_reg;
    logic             s2_adv;

    // result stage
    logic                                m_valid_reg;
    logic [7:0]                          luma_reg;
    logic [7:0]                          luma_next;
    logic [r2nv_pkg::LUMA_OFS_W-1:0]     luma_ofs_reg;
    logic [r2nv_pkg::LUMA_OFS_W-1:0]     luma_ofs_next;
    logic                                chroma_valid_reg;
    logic [7:0]                          cb_reg;
    logic [7:0]                          cb_next;
    logic [7:0]                          cr_reg;
    logic [7:0]                          cr_next;
    logic [r2nv_pkg::CHROMA_OFS_W-1:0]   chroma_ofs_reg;
    logic [r2nv_pkg::CHROMA_OFS_W-1:0]   chroma_ofs_next;
    logic                                frame_end_reg;

    logic [PROD_W-1:0] luma_prod;
    logic [PROD_W-1:0] chroma_prod;
    logic [9:0]        blk_r;
    logic [9:0]        blk_g;
    logic [9:0]        blk_b;
    logic [7:0]        avg_r;
    logic [7:0]        avg_g;
    logic [7:0]        avg_b;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= r2nv_pkg::WIDTH_RESET;
            height_reg <= r2nv_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (r2nv_pkg::cfg_index_t'(cfg_index))
                r2nv_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_wr_data;
                r2nv_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // saturate geometry to 2..max
    always_comb begin
        if (width_reg < r2nv_pkg::DIM_MIN) begin
            w_eff = r2nv_pkg::DIM_MIN;
        end else if (CMP_W'(width_reg) > MAX_W_CMP) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < r2nv_pkg::DIM_MIN) begin
            h_eff = r2nv_pkg::DIM_MIN;
        end else if (CMP_W'(height_reg) > MAX_H_CMP) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // ---------------- accept side ----------------
    assign s2_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s2_adv;
    assign accept  = s_valid && s_ready;

    // a counter past the new last position counts as on it
    assign last_col = CMP_W'(col_reg) >= (CMP_W'(w_eff) - CMP_W'(1));
    assign last_row = CMP_W'(row_reg) >= (CMP_W'(h_eff) - CMP_W'(1));

    assign sum_r = SUM_W'(left_reg[23:16]) + SUM_W'(s_red);
    assign sum_g = SUM_W'(left_reg[15:8])  + SUM_W'(s_green);
    assign sum_b = SUM_W'(left_reg[7:0])   + SUM_W'(s_blue);

    assign line_idx   = IDX_W'(col_reg >> 1);
    assign line_wr_en = accept && col_reg[0] && !row_reg[0];

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= {s_red, s_green, s_blue};
        end
    end

    // even rows write, odd rows use the read; a read also meets a write on even rows, unused
    always_ff @(posedge aclk) begin
        if (line_wr_en) begin
            line_mem[line_idx] <= {sum_r, sum_g, sum_b};
        end
        if (accept) begin
            line_rd_reg <= line_mem[line_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_red_reg    <= s_red;
            s1_green_reg  <= s_green;
            s1_blue_reg   <= s_blue;
            s1_sum_r_reg  <= sum_r;
            s1_sum_g_reg  <= sum_g;
            s1_sum_b_reg  <= sum_b;
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            s1_w_reg      <= w_eff;
            s1_chroma_reg <= col_reg[0] && row_reg[0];
            s1_end_reg    <= last_col && last_row;
        end
    end

    // ---------------- result side ----------------
    assign blk_r = 10'(s1_sum_r_reg) + 10'(line_rd_reg[LINE_W-1:2*SUM_W]);
    assign blk_g = 10'(s1_sum_g_reg) + 10'(line_rd_reg[2*SUM_W-1:SUM_W]);
    assign blk_b = 10'(s1_sum_b_reg) + 10'(line_rd_reg[SUM_W-1:0]);
    assign avg_r = blk_r[9:2];
    assign avg_g = blk_g[9:2];
    assign avg_b = blk_b[9:2];

    assign luma_prod   = PROD_W'(s1_row_reg) * PROD_W'(s1_w_reg);
    assign chroma_prod = PROD_W'(s1_row_reg >> 1) * PROD_W'(s1_w_reg);

    always_comb begin
        luma_next     = r2nv_pkg::luma_byte(s1_red_reg, s1_green_reg, s1_blue_reg);
        luma_ofs_next = r2nv_pkg::LUMA_OFS_W'(luma_prod + PROD_W'(s1_col_reg));
        cb_next         = '0;
        cr_next         = '0;
        chroma_ofs_next = '0;
        if (s1_chroma_reg) begin
            cb_next = r2nv_pkg::chroma_byte(avg_r, avg_g, avg_b, r2nv_pkg::CB_KR,
                                            r2nv_pkg::CB_KG, r2nv_pkg::CB_KB);
            cr_next = r2nv_pkg::chroma_byte(avg_r, avg_g, avg_b, r2nv_pkg::CR_KR,
                                            r2nv_pkg::CR_KG, r2nv_pkg::CR_KB);
            chroma_ofs_next = r2nv_pkg::CHROMA_OFS_W'(chroma_prod
                              + PROD_W'(s1_col_reg - COL_W'(1)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && s1_valid_reg) begin
            luma_reg         <= luma_next;
            luma_ofs_reg     <= luma_ofs_next;
            chroma_valid_reg <= s1_chroma_reg;
            cb_reg           <= cb_next;
            cr_reg           <= cr_next;
            chroma_ofs_reg   <= chroma_ofs_next;
            frame_end_reg    <= s1_end_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_luma          = luma_reg;
    assign m_luma_offset   = luma_ofs_reg;
    assign m_chroma_valid  = chroma_valid_reg;
    assign m_cb            = cb_reg;
    assign m_cr            = cr_reg;
    assign m_chroma_offset = chroma_ofs_reg;
    assign m_frame_end     = frame_end_reg;

    // ---------------- assertions ----------------
    // the input stage keeps its word and line read while the result side is blocked
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_adv |=> s1_valid_reg && $stable(s1_col_reg)
                                    && $stable(line_rd_reg))
        else $error("input stage word changed while stalled");

    // the last pixel of a frame sends the position back to the top left
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_col && last_row |=> col_reg == '0 && row_reg == '0)
        else $error("position did not wrap after frame end");

    // chroma only ever comes from odd row, odd column positions
    a_chroma_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_chroma_reg |-> s1_col_reg[0] && s1_row_reg[0])
        else $error("chroma flagged at an even position");

    // words without chroma carry zero chroma fields
    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !chroma_valid_reg |-> cb_reg == '0 && cr_reg == '0
                                             && chroma_ofs_reg == '0)
        else $error("chroma fields set on a luma only word");

endmodule

@@ tb/rgb_to_nv12_converter_core_tb.sv @@
// self-checking testbench for the rgb to nv12 converter core
module rgb_to_nv12_converter_core_tb;

    localparam int DIM_W        = r2nv_pkg::DIM_W;
    localparam int SUM_W        = r2nv_pkg::SUM_W;
    localparam int LINE_W       = r2nv_pkg::LINE_W;
    localparam int LUMA_OFS_W   = r2nv_pkg::LUMA_OFS_W;
    localparam int CHROMA_OFS_W = r2nv_pkg::CHROMA_OFS_W;

    localparam int DIM_LIMIT     = 4096;
    localparam int LINE_DEPTH    = DIM_LIMIT / 2;
    localparam int MAX_GAP       = 10;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PIXELS = 1000;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0]              luma;
        logic [LUMA_OFS_W-1:0]   luma_offset;
        logic                    chroma_valid;
        logic [7:0]              cb;
        logic [7:0]              cr;
        logic [CHROMA_OFS_W-1:0] chroma_offset;
        logic                    frame_end;
    } nv12_word_t;

    class nv12_converter_model;
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        logic [11:0]       col;
        logic [11:0]       row;
        logic [23:0]       left_rgb;
        logic [LINE_W-1:0] pair_sums [LINE_DEPTH];
        nv12_word_t        pending_words[$];
        int                mismatches = 0;
        int                words_seen = 0;
        int                pixels = 0;
        int                chroma_words = 0;
        int                frames = 0;

        function new();
            width_reg  = r2nv_pkg::WIDTH_RESET;
            height_reg = r2nv_pkg::HEIGHT_RESET;
            col        = '0;
            row        = '0;
            left_rgb   = '0;
        endfunction

        function int used_dim(logic [DIM_W-1:0] v);
            if (v < r2nv_pkg::DIM_MIN) return r2nv_pkg::DIM_MIN;
            if (v > DIM_LIMIT) return DIM_LIMIT;
            return v;
        endfunction

        function logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int v;
            v = ((66 * r + 129 * g + 25 * b + 128) >> 8) + 16;
            return (v > 255) ? 8'd255 : 8'(v);
        endfunction

        // floor shift of a signed sum, then clamp to a byte
        function logic [7:0] chroma_of(int s);
            int v;
            v = ((s + 128) >>> 8) + 128;
            if (v < 0) return 8'd0;
            if (v > 255) return 8'd255;
            return 8'(v);
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            nv12_word_t        word;
            logic [LINE_W-1:0] above;
            int                w;
            int                h;
            int                sr;
            int                sg;
            int                sb;
            int                ar;
            int                ag;
            int                ab;
            logic              last_col;
            logic              last_row;
            w = used_dim(width_reg);
            h = used_dim(height_reg);
            // a counter past a shrunk bound counts as the last column or row
            last_col = (col >= w - 1);
            last_row = (row >= h - 1);
            word = '0;
            word.luma = luma_of(r, g, b);
            word.luma_offset = LUMA_OFS_W'(int'(row) * w + int'(col));
            if (col[0]) begin
                sr = left_rgb[23:16] + r;
                sg = left_rgb[15:8] + g;
                sb = left_rgb[7:0] + b;
                if (!row[0]) begin
                    pair_sums[col[11:1]] = {SUM_W'(sr), SUM_W'(sg), SUM_W'(sb)};
                end else begin
                    above = pair_sums[col[11:1]];
                    ar = (sr + int'(above[26:18])) >>> 2;
                    ag = (sg + int'(above[17:9])) >>> 2;
                    ab = (sb + int'(above[8:0])) >>> 2;
                    word.chroma_valid = 1'b1;
                    word.cb = chroma_of(-38 * ar - 74 * ag + 112 * ab);
                    word.cr = chroma_of(112 * ar - 94 * ag - 18 * ab);
                    word.chroma_offset = CHROMA_OFS_W'(int'(row >> 1) * w + int'(col) - 1);
                    chroma_words++;
                end
            end
            word.frame_end = last_col && last_row;
            if (word.frame_end) frames++;
            pixels++;
            pending_words.push_back(word);
            left_rgb = {r, g, b};
            if (last_col) begin
                col = '0;
                row = last_row ? '0 : row + 1'b1;
            end else begin
                col = col + 1'b1;
            end
        endfunction

        function string describe(nv12_word_t x);
            return $sformatf("y=%0d yofs=%0d cv=%0d cb=%0d cr=%0d cofs=%0d end=%0d",
                             x.luma, x.luma_offset, x.chroma_valid, x.cb, x.cr,
                             x.chroma_offset, x.frame_end);
        endfunction

        function void check_word(nv12_word_t got);
            nv12_word_t want;
            words_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("word %0d arrived with nothing pending: %s", words_seen,
                             describe(got));
                end
                return;
            end
            want = pending_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("word %0d mismatch", words_seen);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function void close_out();
            if (pending_words.size() != 0) begin
                mismatches++;
                $display("%0d words never arrived", pending_words.size());
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [0:0]              cfg_index;
    logic [DIM_W-1:0]        cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [7:0]              s_red;
    logic [7:0]              s_green;
    logic [7:0]              s_blue;
    logic                    m_valid;
    logic                    m_ready;
    logic [7:0]              m_luma;
    logic [LUMA_OFS_W-1:0]   m_luma_offset;
    logic                    m_chroma_valid;
    logic [7:0]              m_cb;
    logic [7:0]              m_cr;
    logic [CHROMA_OFS_W-1:0] m_chroma_offset;
    logic                    m_frame_end;

    nv12_converter_model converter_model = new();
    bit                  src_burst = 1'b0;
    bit                  sink_burst = 1'b0;
    bit                  hold_request = 1'b0;
    int                  cycles = 0;

    rgb_to_nv12_converter_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_luma          (m_luma),
        .m_luma_offset   (m_luma_offset),
        .m_chroma_valid  (m_chroma_valid),
        .m_cb            (m_cb),
        .m_cr            (m_cr),
        .m_chroma_offset (m_chroma_offset),
        .m_frame_end     (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // idle draws, with occasional runs of back-to-back words
    function automatic int pick_gap(inout bit burst);
        if ($urandom_range(0, 31) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] rand_channel();
        int k;
        k = $urandom_range(0, 7);
        if (k == 0) return 8'h00;
        if (k == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(int big);
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return DIM_W'($urandom_range(0, 1));
        if (k <= 2) return DIM_W'($urandom_range(13, big));
        return DIM_W'($urandom_range(2, 12));
    endfunction

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= r2nv_pkg::CFG_FRAME_WIDTH;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_index   <= r2nv_pkg::CFG_FRAME_HEIGHT;
        cfg_wr_data <= h;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        converter_model.width_reg  = w;
        converter_model.height_reg = h;
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = pick_gap(src_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        do @(posedge aclk); while (!s_ready);
        converter_model.note_pixel(r, g, b);
    endtask

    task automatic send_random();
        send_pixel(rand_channel(), rand_channel(), rand_channel());
    endtask

    // bit 0 red, bit 1 green, bit 2 blue, each fully off or on
    task automatic send_corner(input int k);
        send_pixel(k[0] ? 8'hFF : 8'h00, k[1] ? 8'hFF : 8'h00, k[2] ? 8'hFF : 8'h00);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (converter_model.pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : result_sink
        nv12_word_t got;
        int         gap;
        int         held;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                gap = pick_gap(sink_burst);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = {m_luma, m_luma_offset, m_chroma_valid, m_cb, m_cr, m_chroma_offset,
                   m_frame_end};
            converter_model.check_word(got);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int k;
        int n;
        int random_done;
        bit hold_done;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= r2nv_pkg::CFG_FRAME_WIDTH;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_red       <= '0;
        s_green     <= '0;
        s_blue      <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // both registers below range, smallest frame: black, white, blue, red
        set_geometry(13'd0, 13'd1);
        send_corner(0);
        send_corner(7);
        send_corner(4);
        send_corner(1);
        wait_idle();

        // trailing odd column and odd row give no chroma
        set_geometry(13'd3, 13'd3);
        for (k = 0; k < 8; k++) send_corner(k);
        send_pixel(8'd128, 8'd128, 8'd128);
        wait_idle();

        // tall frame, then full width entered on an odd row
        set_geometry(13'd2, 13'd8191);
        for (k = 0; k < 7; k++) send_random();
        wait_idle();
        set_geometry(13'd4096, 13'd8191);
        send_random();
        wait_idle();
        // shrink both: the counters past the new bounds close the frame
        set_geometry(13'd2, 13'd2);
        send_random();
        wait_idle();
        // shrink width partway through an even row
        set_geometry(13'd4, 13'd2);
        repeat (3) send_random();
        wait_idle();
        set_geometry(13'd2, 13'd2);
        repeat (3) send_random();

        random_done = 0;
        hold_done   = 1'b0;
        while (random_done < RANDOM_PIXELS) begin
            if (!hold_done && random_done >= RANDOM_PIXELS / 3) begin
                wait_idle();
                set_geometry(13'd16, 13'd4);
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                wait_idle();
                set_geometry(pick_dim(40), pick_dim(16));
            end
            // otherwise the next frame streams straight on from the last
            n = converter_model.used_dim(converter_model.width_reg) *
                converter_model.used_dim(converter_model.height_reg);
            repeat (n) send_random();
            random_done += n;
        end

        wait_idle();
        converter_model.close_out();
        $display("checked %0d pixels in %0d frames, %0d of them carrying chroma",
                 converter_model.pixels, converter_model.frames, converter_model.chroma_words);
        $display("geometry from 2x2 to 4096 wide, mid-frame shrinks, one %0d-cycle output stall",
                 LONG_HOLD);
        if (converter_model.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
